// ===== sv/ntc_pkg.sv =====
`timescale 1ns / 1ps
package ntc_pkg;
   localparam int VOLT_W = 13;
   localparam int SUPPLY_W = 13;
   localparam int RES_W = 20;
   localparam int TEMP_W = 16;
   localparam int STAT_W = 2;
   localparam int ROM_W = 20;
   localparam int ROM_DEPTH = 256;
   localparam int ROM_DEFINED = 206;
   localparam int QUO_W = 36;
   localparam int TEMP_BASE_C = -55;
   localparam logic signed [TEMP_W-1:0] INVALID_CENTI = -16'sd27315;

   localparam logic [0:0] CSR_SUPPLY = 1'b0;
   localparam logic [0:0] CSR_RESISTOR = 1'b1;

   typedef enum logic [1:0] {
      ST_INTERP = 2'd0,
      ST_COLD = 2'd1,
      ST_HOT = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   typedef logic [ROM_W-1:0] rom_word_type;

   localparam rom_word_type RESIST_ROM [ROM_DEFINED] = '{
      20'd701186,20'd667029,20'd633544,20'd600877,20'd569151,
      20'd538466,20'd508898,20'd480502,20'd453316,20'd427361,
      20'd402643,20'd379158,20'd356888,20'd335810,20'd315893,
      20'd297100,20'd279389,20'd262718,20'd247040,20'd232309,
      20'd218477,20'd205498,20'd193324,20'd181911,20'd171214,
      20'd161190,20'd151798,20'd143000,20'd134757,20'd127035,
      20'd119800,20'd113019,20'd106665,20'd100707,20'd95122,
      20'd89882,20'd84966,20'd80351,20'd76019,20'd71950,
      20'd68126,20'd64531,20'd61151,20'd57970,20'd54977,
      20'd52158,20'd49502,20'd46999,20'd44640,20'd42413,
      20'd40312,20'd38329,20'd36455,20'd34684,20'd33010,
      20'd31568,20'd29928,20'd28510,20'd27167,20'd25895,
      20'd24689,20'd23546,20'd22461,20'd21433,20'd20456,
      20'd19529,20'd18648,20'd17812,20'd17017,20'd16261,
      20'd15542,20'd14858,20'd14207,20'd13587,20'd12998,
      20'd12436,20'd11901,20'd11391,20'd10905,20'd10442,
      20'd10000,20'd9579,20'd9177,20'd8793,20'd8427,
      20'd8078,20'd7744,20'd7426,20'd7122,20'd6831,
      20'd6553,20'd6288,20'd6034,20'd5792,20'd5560,
      20'd5338,20'd5126,20'd4923,20'd4729,20'd4543,
      20'd4365,20'd4195,20'd4032,20'd3876,20'd3727,
      20'd3584,20'd3447,20'd3316,20'd3190,20'd3069,
      20'd2954,20'd2843,20'd2737,20'd2635,20'd2537,
      20'd2444,20'd2354,20'd2268,20'd2185,20'd2106,
      20'd2030,20'd1956,20'd1886,20'd1819,20'd1754,
      20'd1692,20'd1632,20'd1575,20'd1520,20'd1467,
      20'd1416,20'd1367,20'd1320,20'd1275,20'd1232,
      20'd1190,20'd1150,20'd1111,20'd1074,20'd1038,
      20'd1004,20'd970,20'd938,20'd908,20'd878,
      20'd850,20'd822,20'd796,20'd770,20'd745,
      20'd722,20'd699,20'd677,20'd656,20'd635,
      20'd617,20'd597,20'd578,20'd561,20'd544,
      20'd527,20'd511,20'd496,20'd481,20'd467,
      20'd453,20'd439,20'd426,20'd414,20'd402,
      20'd390,20'd379,20'd368,20'd358,20'd347,
      20'd338,20'd328,20'd319,20'd310,20'd301,
      20'd293,20'd285,20'd277,20'd270,20'd262,
      20'd255,20'd248,20'd242,20'd235,20'd229,
      20'd223,20'd217,20'd211,20'd206,20'd200,
      20'd195,20'd190,20'd185,20'd180,20'd176,
      20'd171,20'd167,20'd163,20'd159,20'd155,
      20'd151
   };

   function automatic rom_word_type rom_value(input logic [7:0] idx);
      rom_word_type val;
      val = '0;
      if (int'(idx) < ROM_DEFINED) begin
         val = RESIST_ROM[idx];
      end
      return val;
   endfunction

   // divider control between sequencer and divider
   typedef struct packed {
      logic start;
      logic [QUO_W-1:0] dividend;
      logic [QUO_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;
endpackage

// ===== sv/ntc_if.sv =====
`timescale 1ns / 1ps
interface ntc_req_if;
   logic valid;
   logic ready;
   logic signed [ntc_pkg::VOLT_W-1:0] voltage_mv;
   modport source (output valid, output voltage_mv, input ready);
   modport sink (input valid, input voltage_mv, output ready);
endinterface

interface ntc_rsp_if;
   logic valid;
   logic ready;
   logic signed [ntc_pkg::TEMP_W-1:0] temperature_centi;
   logic [ntc_pkg::STAT_W-1:0] status;
   modport source (output valid, output temperature_centi, output status, input ready);
   modport sink (input valid, input temperature_centi, input status, output ready);
endinterface

interface ntc_csr_if;
   logic valid;
   logic ready;
   logic [0:0] index;
   logic [ntc_pkg::RES_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/ntc_div.sv =====
`timescale 1ns / 1ps
module ntc_div (
   input  logic clock,
   input  logic reset,
   input  ntc_pkg::div_req_type div_req,
   output ntc_pkg::div_rsp_type div_rsp
);
   localparam int W = ntc_pkg::QUO_W;
   logic [W-1:0] quo_ff, quo_in;
   logic [W:0] rem_ff, rem_in;
   logic [W-1:0] dvs_ff, dvs_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [W:0] trial;

   // restoring divide, one quotient bit a cycle
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[W-1:0], quo_ff[W-1]};
      if (div_req.start) begin
         quo_in = div_req.dividend;
         rem_in = '0;
         dvs_in = div_req.divisor;
         cnt_in = 6'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule

// ===== sv/ntc_rom.sv =====
`timescale 1ns / 1ps
module ntc_rom #(
   parameter int DEPTH = 206
) (
   input  logic clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   output ntc_pkg::rom_word_type rdata
);
   ntc_pkg::rom_word_type mem [DEPTH];
   ntc_pkg::rom_word_type rdata_ff;

   // table memory, filled from the package constants
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         mem[i] = ntc_pkg::rom_value(8'(i));
      end
   end

   // synchronous read, registered data output
   always_ff @(posedge clock) begin
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/ntc_voltage_to_temperature.sv =====
`timescale 1ns / 1ps
// channel | dir | handshake        | payload
// req     | in  | valid/ready      | voltage_mv (s13)
// rsp     | out | valid/ready      | temperature_centi (s16), status (2)
// csr     | in  | valid/ready      | index (1), data (20)
// One request at a time, in order: a setup step, the serial resistance divide,
// the end checks, up to 8 table probes on the single table read port plus an
// exit step, the interpolation divide and an output step.
// Clamped and invalid requests skip the later divide.
// Reset is synchronous; registers return to 3300 mV and 100000 ohm.
// A waiting result is held in the output register; the next request is taken
// as soon as that result leaves.
module ntc_voltage_to_temperature #(
   parameter int TABLE_ENTRIES = 206
) (
   input logic clock,
   input logic reset,
   ntc_req_if.sink req,
   ntc_rsp_if.source rsp,
   ntc_csr_if.sink csr
);
   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int W = ntc_pkg::QUO_W;
   localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_MUL  = 9'b000000010,
      S_DIV1 = 9'b000000100,
      S_END0 = 9'b000001000,
      S_END1 = 9'b000010000,
      S_PROBE = 9'b000100000,
      S_CMP  = 9'b001000000,
      S_DIV2 = 9'b010000000,
      S_OUT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [ntc_pkg::SUPPLY_W-1:0] supply_ff;
   logic [ntc_pkg::RES_W-1:0] resistor_ff;
   logic signed [ntc_pkg::VOLT_W-1:0] volt_ff;
   logic signed [15:0] num_diff, den_sum;
   logic [W-1:0] r_ff;
   logic [AW-1:0] lo_ff, hi_ff, addr;
   logic [ntc_pkg::ROM_W-1:0] rlo_ff, rhi_ff;
   logic [ntc_pkg::ROM_W-1:0] rom_q;
   logic [1:0] stepc_ff;
   logic div_issued_ff;
   logic rsp_valid_ff;
   logic signed [ntc_pkg::TEMP_W-1:0] temp_ff;
   logic [ntc_pkg::STAT_W-1:0] stat_ff;
   logic div_start_ff;
   logic [W-1:0] dividend_ff, divisor_ff;
   ntc_pkg::div_req_type dreq;
   ntc_pkg::div_rsp_type drsp;
   logic [AW-1:0] mid;

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.temperature_centi = temp_ff;
   assign rsp.status = stat_ff;

   assign num_diff = 16'(supply_ff) - (16'(volt_ff) <<< 1);
   assign den_sum = 16'(supply_ff) + (16'(volt_ff) <<< 1);
   assign mid = AW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);

   assign dreq = '{start: div_start_ff, dividend: dividend_ff, divisor: divisor_ff};

   ntc_div u_div (.clock(clock), .reset(reset), .div_req(dreq), .div_rsp(drsp));
   ntc_rom #(.DEPTH(TABLE_ENTRIES)) u_rom (.clock(clock), .addr(addr), .rdata(rom_q));

   // table address by step
   always_comb begin
      unique case (state_ff)
         S_END0: addr = '0;
         S_END1: addr = LAST;
         default: addr = mid;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= 13'd3300;
         resistor_ff <= 20'd100000;
      end else if (csr.valid) begin
         unique case (csr.index)
            ntc_pkg::CSR_SUPPLY: supply_ff <= csr.data[ntc_pkg::SUPPLY_W-1:0];
            ntc_pkg::CSR_RESISTOR: resistor_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // divider start pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= ((state_ff == S_MUL) && !(den_sum <= 0 || num_diff < 0))
            || ((state_ff == S_DIV2) && !div_issued_ff);
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         div_issued_ff <= 1'b0;
         stepc_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req.valid && req.ready) begin
               volt_ff <= req.voltage_mv;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               if (den_sum <= 0 || num_diff < 0) begin
                  temp_ff <= ntc_pkg::INVALID_CENTI;
                  stat_ff <= ntc_pkg::ST_INVALID;
                  state_ff <= S_OUT;
               end else begin
                  dividend_ff <= W'(resistor_ff) * W'(num_diff[13:0]);
                  divisor_ff <= W'(den_sum[13:0]) * W'(10);
                  state_ff <= S_DIV1;
               end
            end
            S_DIV1: if (drsp.done) begin
               r_ff <= drsp.quotient;
               state_ff <= S_END0;
               stepc_ff <= '0;
            end
            S_END0: begin
               if (stepc_ff == 2'd1) begin
                  if (r_ff >= W'(rom_q)) begin
                     temp_ff <= 16'(ntc_pkg::TEMP_BASE_C * 100);
                     stat_ff <= ntc_pkg::ST_COLD;
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_END1;
                     stepc_ff <= '0;
                  end
               end else begin
                  stepc_ff <= stepc_ff + 2'd1;
               end
            end
            S_END1: begin
               stepc_ff <= stepc_ff + 2'd1;
               if (stepc_ff == 2'd1) begin
                  if (r_ff <= W'(rom_q)) begin
                     temp_ff <= 16'((TABLE_ENTRIES - 1 + ntc_pkg::TEMP_BASE_C) * 100);
                     stat_ff <= ntc_pkg::ST_HOT;
                     state_ff <= S_OUT;
                  end else begin
                     lo_ff <= '0;
                     hi_ff <= LAST;
                     state_ff <= S_PROBE;
                  end
               end
            end
            S_PROBE: begin
               if (AW'(hi_ff - lo_ff) > AW'(1)) state_ff <= S_CMP;
               else begin
                  rlo_ff <= ntc_pkg::rom_value(8'(lo_ff));
                  rhi_ff <= ntc_pkg::rom_value(8'(hi_ff));
                  div_issued_ff <= 1'b0;
                  state_ff <= S_DIV2;
               end
            end
            S_CMP: begin
               if (r_ff > W'(rom_q)) hi_ff <= mid;
               else lo_ff <= mid;
               state_ff <= S_PROBE;
            end
            S_DIV2: begin
               if (!div_issued_ff) begin
                  dividend_ff <= W'((rlo_ff - r_ff[ntc_pkg::ROM_W-1:0]) * 27'd100);
                  divisor_ff <= W'(rlo_ff - rhi_ff);
                  div_issued_ff <= 1'b1;
               end else if (drsp.done) begin
                  temp_ff <= 16'((int'(lo_ff) + ntc_pkg::TEMP_BASE_C) * 100)
                     + 16'(drsp.quotient[7:0]);
                  stat_ff <= ntc_pkg::ST_INTERP;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // result appears only when its request has finished
   a_out_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result without finished request");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready)
      else $error("request taken while busy");
   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> lo_ff < hi_ff)
      else $error("search bracket inverted");
endmodule

// ===== bench/ntc_checker.sv =====
`timescale 1ns / 1ps
module ntc_checker (
   input logic clock,
   input logic reset,
   ntc_req_if.sink req,
   ntc_rsp_if.sink rsp,
   ntc_csr_if.sink csr,
   output int fail_count,
   output int pending_count
);
   typedef struct packed {
      logic signed [ntc_pkg::TEMP_W-1:0] temperature_centi;
      ntc_pkg::status_type status;
   } temp_result_type;

   logic [ntc_pkg::SUPPLY_W-1:0] supply_mv;
   logic [ntc_pkg::RES_W-1:0] resistor_ohm;
   temp_result_type expected_temps [$];

   function automatic longint unsigned table_at(int idx);
      if (idx < ntc_pkg::ROM_DEFINED) begin
         return ntc_pkg::RESIST_ROM[idx];
      end
      return 0;
   endfunction

   // expected temperature for one voltage under the current settings
   function automatic temp_result_type convert_voltage(
      logic signed [ntc_pkg::VOLT_W-1:0] v);
      temp_result_type res;
      longint den;
      longint num;
      longint unsigned r;
      int lo;
      int hi;
      int mid;
      longint unsigned r_lo;
      longint unsigned r_hi;
      den = 10 * (longint'(supply_mv) + 2 * longint'(v));
      num = longint'(resistor_ohm) * (longint'(supply_mv) - 2 * longint'(v));
      if (den <= 0 || num < 0) begin
         res.temperature_centi = ntc_pkg::INVALID_CENTI;
         res.status = ntc_pkg::ST_INVALID;
         return res;
      end
      r = num / den;
      if (r >= table_at(0)) begin
         res.temperature_centi = ntc_pkg::TEMP_BASE_C * 100;
         res.status = ntc_pkg::ST_COLD;
         return res;
      end
      if (r <= table_at(ntc_pkg::ROM_DEFINED - 1)) begin
         res.temperature_centi = (ntc_pkg::ROM_DEFINED - 1 + ntc_pkg::TEMP_BASE_C) * 100;
         res.status = ntc_pkg::ST_HOT;
         return res;
      end
      lo = 0;
      hi = ntc_pkg::ROM_DEFINED - 1;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (r > table_at(mid)) hi = mid;
         else lo = mid;
      end
      r_lo = table_at(lo);
      r_hi = table_at(hi);
      res.temperature_centi = (lo + ntc_pkg::TEMP_BASE_C) * 100
         + int'(((r_lo - r) * 100 * (hi - lo)) / (r_lo - r_hi));
      res.status = ntc_pkg::ST_INTERP;
      return res;
   endfunction

   // track settings, predict each request, compare each result
   always @(posedge clock) begin
      temp_result_type exp_res;
      int errs;
      errs = 0;
      if (reset) begin
         supply_mv <= 13'd3300;
         resistor_ohm <= 20'd100000;
         expected_temps.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == ntc_pkg::CSR_SUPPLY) begin
               supply_mv <= csr.data[ntc_pkg::SUPPLY_W-1:0];
            end else if (csr.index == ntc_pkg::CSR_RESISTOR) begin
               resistor_ohm <= csr.data;
            end
         end
         if (req.valid && req.ready) begin
            expected_temps.push_back(convert_voltage(req.voltage_mv));
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_temps.size() == 0) begin
               $error("unexpected result temperature_centi=%0d status=%0d",
                  rsp.temperature_centi, rsp.status);
               errs++;
            end else begin
               exp_res = expected_temps.pop_front();
               if (rsp.temperature_centi !== exp_res.temperature_centi) begin
                  $error("temperature_centi expected %0d actual %0d",
                     exp_res.temperature_centi, rsp.temperature_centi);
                  errs++;
               end
               if (rsp.status !== exp_res.status) begin
                  $error("status expected %0d actual %0d", exp_res.status, rsp.status);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending_count <= expected_temps.size();
      end
   end
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
   localparam int VW = ntc_pkg::VOLT_W;
   localparam int RW = ntc_pkg::RES_W;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int fail_count;
   int pending_count;
   bit quiet_phase = 1'b0;
   bit sender_idle_ok = 1'b1;

   ntc_req_if req ();
   ntc_rsp_if rsp ();
   ntc_csr_if csr ();

   ntc_voltage_to_temperature u_top (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   ntc_checker u_checker (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.sink), .csr(csr.sink),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.voltage_mv = '0;
      csr.valid = 1'b0;
      csr.index = ntc_pkg::CSR_SUPPLY;
      csr.data = '0;
      rsp.ready = 1'b0;
   end

   // receiver stalls in random bursts, none near the end
   initial begin
      int n;
      @(posedge clock);
      forever begin
         n = $urandom_range(1, 14);
         if (!quiet_phase && $urandom_range(0, 2) == 0) begin
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
         repeat (n) @(posedge clock);
      end
   end

   task automatic write_reg(logic [0:0] idx, logic [RW-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   // valid stays high into the next request unless the sender idles
   task automatic send_voltage(logic signed [VW-1:0] v);
      if (!quiet_phase && sender_idle_ok && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.voltage_mv <= v;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic wait_empty();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic drain_results();
      wait_empty();
      repeat (100) @(posedge clock);
   endtask

   // voltage that lands the resistance inside the table most of the time
   function automatic logic signed [VW-1:0] pick_voltage(int supply);
      int lim;
      lim = supply / 2;
      case ($urandom_range(0, 9))
         0: return VW'($urandom);
         1: return VW'(-lim + int'($urandom_range(0, 3)) - 1);
         2: return VW'(lim + int'($urandom_range(0, 3)) - 1);
         default: return VW'(int'($urandom_range(0, 2 * lim)) - lim);
      endcase
   endfunction

   task automatic random_phase(int count, int supply);
      repeat (count) send_voltage(pick_voltage(supply));
   endtask

   initial begin
      int supply;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, field extremes and each special case
      send_voltage(-13'sd4096);
      send_voltage(13'sd4095);
      send_voltage(13'sd0);
      send_voltage(-13'sd1650);
      send_voltage(-13'sd1649);
      send_voltage(13'sd1650);
      send_voltage(13'sd1651);
      send_voltage(-13'sd1500);
      send_voltage(13'sd1500);
      send_voltage(13'sd1640);
      send_voltage(-13'sd1);
      send_voltage(13'sd1);
      send_voltage(13'sd2730);
      send_voltage(-13'sd2731);
      send_voltage(13'sd1365);
      drain_results();

      // zero resistor clamps hot
      write_reg(ntc_pkg::CSR_RESISTOR, 20'd0);
      send_voltage(13'sd100);
      send_voltage(-13'sd1000);
      drain_results();
      write_reg(ntc_pkg::CSR_SUPPLY, 20'h01FFF);
      write_reg(ntc_pkg::CSR_RESISTOR, 20'hFFFFF);
      send_voltage(13'sd4095);
      send_voltage(-13'sd4096);
      send_voltage(13'sd0);
      drain_results();

      // sweep several settings, extremes included
      write_reg(ntc_pkg::CSR_SUPPLY, 20'd3300);
      write_reg(ntc_pkg::CSR_RESISTOR, 20'd100000);
      random_phase(300, 3300);
      // sender holds off until every result is back
      sender_idle_ok = 1'b0;
      wait_empty();
      sender_idle_ok = 1'b1;
      random_phase(50, 3300);
      drain_results();
      write_reg(ntc_pkg::CSR_SUPPLY, 20'd1000);
      write_reg(ntc_pkg::CSR_RESISTOR, 20'd1);
      random_phase(100, 1000);
      drain_results();
      write_reg(ntc_pkg::CSR_SUPPLY, 20'd5000);
      write_reg(ntc_pkg::CSR_RESISTOR, 20'd1000000);
      random_phase(250, 5000);
      drain_results();
      write_reg(ntc_pkg::CSR_SUPPLY, 20'd2500);
      write_reg(ntc_pkg::CSR_RESISTOR, 20'd10000);
      random_phase(200, 2500);
      drain_results();
      supply = $urandom_range(1000, 5000);
      write_reg(ntc_pkg::CSR_SUPPLY, RW'(supply));
      write_reg(ntc_pkg::CSR_RESISTOR, RW'($urandom_range(1000, 1000000)));
      random_phase(150, supply);
      quiet_phase = 1'b1;
      random_phase(200, supply);
      drain_results();

      if (fail_count == 0) begin
         $display("** ntc_voltage_to_temperature: PASSED **");
      end else begin
         $display("** ntc_voltage_to_temperature: FAILED **");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("** ntc_voltage_to_temperature: FAILED **");
      $finish;
   end
endmodule
